[hw/rtl/sfl_pkg.sv]
package sfl_pkg;

   localparam int ADDR_W   = 64;
   localparam int TAG_W    = 16;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_CLEARED  = 3'd2,
      ST_NONE     = 3'd3,
      ST_EXACT    = 3'd4,
      ST_BELOW    = 3'd5
   } status_type;

   typedef struct packed {
      logic              lt;
      logic              eq;
      logic [ADDR_W-1:0] diff;
   } alu_res_type;

endpackage

[hw/rtl/sfl_req_if.sv]
interface sfl_req_if import sfl_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ADDR_W-1:0] address;
   logic [TAG_W-1:0]  tag;

   modport source (output valid, output command, output address, output tag, input ready);
   modport sink (input valid, input command, input address, input tag, output ready);

endinterface

[hw/rtl/sfl_rsp_if.sv]
interface sfl_rsp_if import sfl_pkg::*; #(parameter int CNT_W = 11) ();

   logic              valid;
   logic              ready;
   status_type        status;
   logic [TAG_W-1:0]  found_tag;
   logic [ADDR_W-1:0] offset;
   logic [CNT_W-1:0]  entry_count;

   modport source (output valid, output status, output found_tag, output offset,
                   output entry_count, input ready);
   modport sink (input valid, input status, input found_tag, input offset,
                 input entry_count, output ready);

endinterface

[hw/rtl/sfl_table.sv]
module sfl_table import sfl_pkg::*; #(
   parameter int DEPTH    = 1024,
   parameter int TAG_BITS = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_idx,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [TAG_BITS-1:0]        wr_tag,
   input  logic [$clog2(DEPTH)-1:0]   rd_idx,
   output logic [ADDR_W-1:0]          rd_addr_ff,
   output logic [TAG_BITS-1:0]        rd_tag_ff
);

   logic [ADDR_W-1:0]   addr_mem [DEPTH];
   logic [TAG_BITS-1:0] tag_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[wr_idx] <= wr_addr;
         tag_mem[wr_idx]  <= wr_tag;
      end
      rd_addr_ff <= addr_mem[rd_idx];
      rd_tag_ff  <= tag_mem[rd_idx];
   end

endmodule

[hw/rtl/sfl_alu.sv]
module sfl_alu import sfl_pkg::*; (
   input  logic [ADDR_W-1:0] entry_addr,
   input  logic [ADDR_W-1:0] key,
   output alu_res_type       res
);

   always_comb begin
      res.lt   = entry_addr < key;
      res.eq   = entry_addr == key;
      res.diff = key - entry_addr;
   end

endmodule

[hw/rtl/sorted_address_floor_lookup.sv]
// lookup: binary search over the table, one memory read per step, then a read of the
// entry found (and of the one below it when the match is not exact) and the result
// insert: same search, then the entries above the slot are moved up one by one, then the new entry
// clear and insert into a full table go straight to the result; the next beat is taken once the result is queued
// synchronous reset empties the table; stored entries are not cleared
module sorted_address_floor_lookup import sfl_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int TAG_BITS    = 16
) (
   input  logic      clock,
   input  logic      reset,
   sfl_req_if.sink   req_ch,
   sfl_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SEARCH   = 7'b0000010,
      S_LK_EQ    = 7'b0000100,
      S_LK_BELOW = 7'b0001000,
      S_SHIFT    = 7'b0010000,
      S_INS_WR   = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              lookup_ff, lookup_in;
   status_type        res_status_ff, res_status_in;
   logic [TAG_W-1:0]  res_tag_ff, res_tag_in;
   logic [ADDR_W-1:0] res_off_ff, res_off_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [ADDR_W-1:0] rsp_off_ff, rsp_off_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx, rd_idx;
   logic [ADDR_W-1:0]   wr_addr, rd_addr_q;
   logic [TAG_BITS-1:0] wr_tag, rd_tag_q;
   alu_res_type         alu_res;

   logic             go_right;
   logic [CNT_W-1:0] step_lo, step_hi, step_mid, start_mid;
   logic [CNT_W:0]   step_sum;
   logic             out_free;

   sfl_table #(.DEPTH(TABLE_DEPTH), .TAG_BITS(TAG_BITS)) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_addr    (wr_addr),
      .wr_tag     (wr_tag),
      .rd_idx     (rd_idx),
      .rd_addr_ff (rd_addr_q),
      .rd_tag_ff  (rd_tag_q)
   );

   sfl_alu u_alu (
      .entry_addr (rd_addr_q),
      .key        (key_ff),
      .res        (alu_res)
   );

   // one halving step against the entry read last cycle
   always_comb begin
      go_right  = lookup_ff ? alu_res.lt : (alu_res.lt | alu_res.eq);
      step_lo   = go_right ? CNT_W'(mid_ff + 1'b1) : lo_ff;
      step_hi   = go_right ? hi_ff : mid_ff;
      step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
      step_mid  = step_sum[CNT_W:1];
      start_mid = count_ff >> 1;
      out_free  = !rsp_valid_ff || rsp_ch.ready;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      lookup_in     = lookup_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_off_in    = res_off_ff;
      rd_idx        = mid_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_idx        = IDX_W'(idx_ff + 1'b1);
      wr_addr       = rd_addr_q;
      wr_tag        = rd_tag_q;

      unique case (state_ff)
         S_IDLE: begin
            rd_idx = start_mid[IDX_W-1:0];
            if (req_ch.valid) begin
               key_in     = req_ch.address;
               tag_in     = req_ch.tag;
               lo_in      = '0;
               hi_in      = count_ff;
               mid_in     = start_mid;
               res_tag_in = '0;
               res_off_in = '0;
               unique case (req_ch.command)
                  CMD_CLEAR: begin
                     lookup_in     = 1'b0;
                     count_in      = '0;
                     res_status_in = ST_CLEARED;
                     state_in      = S_DONE;
                  end
                  CMD_INSERT: begin
                     lookup_in = 1'b0;
                     if (count_ff >= DEPTH_C) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else if (count_ff == '0) begin
                        state_in = S_INS_WR;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     lookup_in = 1'b1;
                     if (count_ff == '0) begin
                        res_status_in = ST_NONE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
               endcase
            end
         end
         S_SEARCH: begin
            lo_in  = step_lo;
            hi_in  = step_hi;
            mid_in = step_mid;
            if (step_lo < step_hi) begin
               rd_idx = step_mid[IDX_W-1:0];
            end else if (lookup_ff) begin
               rd_idx   = step_lo[IDX_W-1:0];
               state_in = S_LK_EQ;
            end else if (step_lo < count_ff) begin
               idx_in   = IDX_W'(count_ff - 1'b1);
               rd_idx   = IDX_W'(count_ff - 1'b1);
               state_in = S_SHIFT;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_LK_EQ: begin
            if ((lo_ff < count_ff) && alu_res.eq) begin
               res_status_in = ST_EXACT;
               res_tag_in    = TAG_W'(rd_tag_q);
               res_off_in    = '0;
               state_in      = S_DONE;
            end else if (lo_ff != '0) begin
               rd_idx   = IDX_W'(lo_ff - 1'b1);
               state_in = S_LK_BELOW;
            end else begin
               res_status_in = ST_NONE;
               state_in      = S_DONE;
            end
         end
         S_LK_BELOW: begin
            res_status_in = ST_BELOW;
            res_tag_in    = TAG_W'(rd_tag_q);
            res_off_in    = alu_res.diff;
            state_in      = S_DONE;
         end
         S_SHIFT: begin
            // move entry up by one while the next lower one is read
            wr_en = 1'b1;
            if (CNT_W'(idx_ff) > lo_ff) begin
               idx_in = IDX_W'(idx_ff - 1'b1);
               rd_idx = IDX_W'(idx_ff - 1'b1);
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            wr_en         = 1'b1;
            wr_idx        = lo_ff[IDX_W-1:0];
            wr_addr       = key_ff;
            wr_tag        = TAG_BITS'(tag_ff);
            count_in      = CNT_W'(count_ff + 1'b1);
            res_status_in = ST_INSERTED;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_count_in  = rsp_count_ff;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_tag_in    = res_tag_ff;
         rsp_off_in    = res_off_ff;
         rsp_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      lookup_ff     <= lookup_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found_tag   = rsp_tag_ff;
   assign rsp_ch.offset      = rsp_off_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above table depth");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff < hi_ff))
      else $error("search window empty while searching");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.command == CMD_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty table");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WR) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not bump entry count");
`endif

endmodule
